/* rtl/rtb_pkg.sv */
// Package: shared types, codes and defaults for the tagged reorder buffer.
`default_nettype none
package rtb_pkg;

  localparam int ENTRIES_DEF  = 64;
  localparam int TAG_BITS_DEF = 32;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_EXEC   = 3'd1,
    OP_BRANCH = 3'd2,
    OP_QUERY  = 3'd3,
    OP_SQUASH = 3'd4,
    OP_COMMIT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_HEAD_NR  = 2'd3
  } status_e;

  localparam logic [1:0] EXEC_NORMAL  = 2'd0;
  localparam logic [1:0] EXEC_CONTROL = 2'd2;

  localparam logic [1:0] KIND_REG    = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_BRANCH = 2'd2;
  localparam logic [1:0] KIND_LINK   = 2'd3;

  typedef struct packed {
    logic latch;
    logic dispatch;
    logic check;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/reorder_buffer_tagged_unit.sv */
// Top level: tagged reorder buffer, one operation per transfer.
//
//  channel | handshake            | payload
//  input   | in_valid / in_stall  | operation .. checkpoint
//  output  | out_valid / out_stall| status .. query_value
//
// Push, unused codes and any operation on an empty buffer finish in the dispatch state.
// Tag lookups and squash scan one slot at a time from the head, with a wait state
// between checks, set by the single registered read port of the slot memories.
// Commit reads the head slot and finishes in the check state. One item is in flight at a time.
// Reset clears pointers and last tag; slot contents need no clearing.
// A held result stalls the next transfer only while out_stall is high.
`default_nettype none
module reorder_buffer_tagged_unit #(
  parameter int ENTRIES  = rtb_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = rtb_pkg::TAG_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] tag,
  input  wire logic [31:0] data_value,
  input  wire logic [1:0]  exec_kind,
  input  wire logic [1:0]  entry_kind,
  input  wire logic [4:0]  dest_reg,
  input  wire logic        halt_flag,
  input  wire logic [31:0] instr_pc,
  input  wire logic [31:0] predicted_pc,
  input  wire logic        push_value_ready,
  input  wire logic        push_commit_ready,
  input  wire logic [31:0] checkpoint,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      new_tag,
  output logic             commit_valid,
  output logic             commit_halt,
  output logic [4:0]       commit_dest,
  output logic [1:0]       commit_kind,
  output logic [31:0]      commit_value,
  output logic [31:0]      commit_pc,
  output logic [31:0]      commit_predicted_pc,
  output logic [31:0]      commit_checkpoint,
  output logic             query_ready,
  output logic [31:0]      query_value
);
  import rtb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rtb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtb_datapath #(.ENTRIES(ENTRIES), .TAG_BITS(TAG_BITS)) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .operation           (operation),
    .tag                 (tag),
    .data_value          (data_value),
    .exec_kind           (exec_kind),
    .entry_kind          (entry_kind),
    .dest_reg            (dest_reg),
    .halt_flag           (halt_flag),
    .instr_pc            (instr_pc),
    .predicted_pc        (predicted_pc),
    .push_value_ready    (push_value_ready),
    .push_commit_ready   (push_commit_ready),
    .checkpoint          (checkpoint),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .status              (status),
    .new_tag             (new_tag),
    .commit_valid        (commit_valid),
    .commit_halt         (commit_halt),
    .commit_dest         (commit_dest),
    .commit_kind         (commit_kind),
    .commit_value        (commit_value),
    .commit_pc           (commit_pc),
    .commit_predicted_pc (commit_predicted_pc),
    .commit_checkpoint   (commit_checkpoint),
    .query_ready         (query_ready),
    .query_value         (query_value)
  );
endmodule
`default_nettype wire

/* rtl/rtb_ctrl.sv */
// Controller: sequences dispatch and the slot-by-slot scan.
`default_nettype none
module rtb_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire rtb_pkg::sts_t sts,
  output rtb_pkg::cmd_t     cmd
);
  import rtb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DISP  = 4'b0010,
    S_WAIT  = 4'b0100,
    S_CHECK = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = !((state == S_IDLE) && !sts.out_busy);
  assign accept   = in_valid && !in_stall;

  assign cmd.latch    = accept;
  assign cmd.dispatch = (state == S_DISP);
  assign cmd.check    = (state == S_CHECK);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_DISP;
      S_DISP:  state_next = sts.fin ? S_IDLE : S_CHECK;
      S_CHECK: state_next = sts.fin ? S_IDLE : S_WAIT;
      S_WAIT:  state_next = S_CHECK;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

`ifndef ASSERT_OFF
  a_accept_disp: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DISP) else $error("transfer not dispatched");
  a_wait_check: assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT |=> state == S_CHECK) else $error("scan step lost");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("input open while busy");
`endif
endmodule
`default_nettype wire

/* rtl/rtb_datapath.sv */
// Datapath: slot memories, pointers, tag compare and result register.
`default_nettype none
module rtb_datapath #(
  parameter int ENTRIES  = rtb_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = rtb_pkg::TAG_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rtb_pkg::cmd_t cmd,
  output rtb_pkg::sts_t    sts,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] tag,
  input  wire logic [31:0] data_value,
  input  wire logic [1:0]  exec_kind,
  input  wire logic [1:0]  entry_kind,
  input  wire logic [4:0]  dest_reg,
  input  wire logic        halt_flag,
  input  wire logic [31:0] instr_pc,
  input  wire logic [31:0] predicted_pc,
  input  wire logic        push_value_ready,
  input  wire logic        push_commit_ready,
  input  wire logic [31:0] checkpoint,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      new_tag,
  output logic             commit_valid,
  output logic             commit_halt,
  output logic [4:0]       commit_dest,
  output logic [1:0]       commit_kind,
  output logic [31:0]      commit_value,
  output logic [31:0]      commit_pc,
  output logic [31:0]      commit_predicted_pc,
  output logic [31:0]      commit_checkpoint,
  output logic             query_ready,
  output logic [31:0]      query_value
);
  import rtb_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = (TAG_BITS > 32) ? TAG_BITS : 32;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  op_e           op_q;
  logic [31:0]   tag_q, dval_q, pc_q, ppc_q, ck_q;
  logic [1:0]    ekind_q, kind_q;
  logic [4:0]    dest_q;
  logic          halt_q, vr_q, cr_q;

  logic [IW-1:0]       head, tail, ptr;
  logic [TAG_BITS-1:0] last_tag;

  logic [TAG_BITS-1:0] tag_mem  [ENTRIES];
  logic [1:0]          kind_mem [ENTRIES];
  logic [4:0]          dest_mem [ENTRIES];
  logic                halt_mem [ENTRIES];
  logic [31:0]         val_mem  [ENTRIES];
  logic [31:0]         pc_mem   [ENTRIES];
  logic [31:0]         ppc_mem  [ENTRIES];
  logic [31:0]         ck_mem   [ENTRIES];
  logic                vf_mem   [ENTRIES];
  logic                cf_mem   [ENTRIES];

  logic [TAG_BITS-1:0] rd_tag;
  logic [1:0]          rd_kind;
  logic [4:0]          rd_dest;
  logic                rd_halt, rd_vf, rd_cf;
  logic [31:0]         rd_val, rd_pc, rd_ppc, rd_ck;

  logic [IW-1:0]       ptr_inc, tail_inc;
  logic [TAG_BITS-1:0] lt_inc;
  logic                full, empty, hit, younger;
  logic                fin, adv, push_we, exec_val, exec_cf, do_commit, do_query, do_trunc;
  status_e             f_status;
  logic                val_we, cf_we;
  logic [IW-1:0]       wa;

  function automatic logic exec_kind_ok(input logic [1:0] ek, input logic [1:0] k);
    exec_kind_ok = (ek == EXEC_NORMAL && (k == KIND_REG || k == KIND_STORE)) ||
                   (ek == EXEC_CONTROL && k == KIND_LINK);
  endfunction

  assign ptr_inc  = (ptr == LAST) ? '0 : ptr + 1'b1;
  assign tail_inc = (tail == LAST) ? '0 : tail + 1'b1;
  assign lt_inc   = last_tag + 1'b1;
  assign full     = (tail_inc == head);
  assign empty    = (head == tail);
  assign hit      = (CW'(rd_tag) == CW'(tag_q));
  assign younger  = (CW'(rd_tag) > CW'(tag_q));

  always_comb begin
    fin = 1'b0; adv = 1'b0; push_we = 1'b0; exec_val = 1'b0; exec_cf = 1'b0;
    do_commit = 1'b0; do_query = 1'b0; do_trunc = 1'b0; f_status = ST_DONE;
    if (cmd.dispatch) begin
      unique case (op_q) inside
        OP_PUSH: begin
          fin = 1'b1;
          if (full) f_status = ST_FULL;
          else      push_we  = 1'b1;
        end
        OP_EXEC, OP_BRANCH, OP_QUERY: begin
          if (empty) begin
            fin = 1'b1; f_status = ST_NOTFOUND;
          end
        end
        OP_SQUASH: if (empty) fin = 1'b1;
        OP_COMMIT: begin
          if (empty) begin
            fin = 1'b1; f_status = ST_HEAD_NR;
          end
        end
        default: fin = 1'b1;
      endcase
    end else if (cmd.check) begin
      unique case (op_q) inside
        OP_EXEC, OP_BRANCH, OP_QUERY: begin
          if (hit) begin
            fin = 1'b1;
            if (op_q == OP_EXEC) begin
              if (exec_kind_ok(ekind_q, rd_kind) && rd_kind == KIND_REG) exec_val = 1'b1;
              if (exec_kind_ok(ekind_q, rd_kind)) exec_cf = 1'b1;
            end else if (op_q == OP_BRANCH) begin
              exec_cf = (rd_kind == KIND_BRANCH);
            end else begin
              do_query = 1'b1;
            end
          end else if (ptr_inc == tail) begin
            fin = 1'b1; f_status = ST_NOTFOUND;
          end else begin
            adv = 1'b1;
          end
        end
        OP_SQUASH: begin
          if (younger) begin
            fin = 1'b1; do_trunc = 1'b1;
          end else if (ptr_inc == tail) begin
            fin = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
        OP_COMMIT: begin
          fin = 1'b1;
          if (rd_cf) do_commit = 1'b1;
          else       f_status  = ST_HEAD_NR;
        end
        default: fin = 1'b1;
      endcase
    end
  end

  assign sts.fin      = fin;
  assign sts.out_busy = out_valid && out_stall;

  assign wa     = push_we ? tail : ptr;
  assign val_we = push_we || exec_val;
  assign cf_we  = push_we || exec_cf;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= op_e'(operation);
      tag_q   <= tag;
      dval_q  <= data_value;
      ekind_q <= exec_kind;
      kind_q  <= entry_kind;
      dest_q  <= dest_reg;
      halt_q  <= halt_flag;
      pc_q    <= instr_pc;
      ppc_q   <= predicted_pc;
      vr_q    <= push_value_ready;
      cr_q    <= push_commit_ready;
      ck_q    <= checkpoint;
    end
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      tag_mem[tail]  <= lt_inc;
      kind_mem[tail] <= kind_q;
      dest_mem[tail] <= dest_q;
      halt_mem[tail] <= halt_q;
      pc_mem[tail]   <= pc_q;
      ppc_mem[tail]  <= ppc_q;
      ck_mem[tail]   <= ck_q;
    end
    if (val_we) begin
      val_mem[wa] <= dval_q;
      vf_mem[wa]  <= push_we ? (vr_q | cr_q) : 1'b1;
    end
    if (cf_we) cf_mem[wa] <= push_we ? cr_q : 1'b1;
    rd_tag  <= tag_mem[ptr];
    rd_kind <= kind_mem[ptr];
    rd_dest <= dest_mem[ptr];
    rd_halt <= halt_mem[ptr];
    rd_val  <= val_mem[ptr];
    rd_pc   <= pc_mem[ptr];
    rd_ppc  <= ppc_mem[ptr];
    rd_ck   <= ck_mem[ptr];
    rd_vf   <= vf_mem[ptr];
    rd_cf   <= cf_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      ptr      <= '0;
      last_tag <= '0;
    end else begin
      if (cmd.latch)      ptr <= head;
      else if (adv)       ptr <= ptr_inc;
      if (push_we) begin
        tail     <= tail_inc;
        last_tag <= lt_inc;
      end
      if (do_trunc)  tail <= ptr;
      if (do_commit) head <= ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status              <= f_status;
      new_tag             <= push_we ? 32'(lt_inc) : '0;
      commit_valid        <= do_commit;
      commit_halt         <= do_commit ? rd_halt : 1'b0;
      commit_dest         <= do_commit ? rd_dest : '0;
      commit_kind         <= do_commit ? rd_kind : '0;
      commit_value        <= do_commit ? rd_val : '0;
      commit_pc           <= do_commit ? rd_pc : '0;
      commit_predicted_pc <= do_commit ? rd_ppc : '0;
      commit_checkpoint   <= do_commit ? rd_ck : '0;
      query_ready         <= do_query ? rd_vf : 1'b0;
      query_value         <= do_query ? rd_val : '0;
    end
  end

`ifndef ASSERT_OFF
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    fin |=> out_valid) else $error("result not registered");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_we |=> head != tail) else $error("push left buffer empty");
  a_one_scan: assert property (@(posedge clk) disable iff (rst)
    !(adv && fin)) else $error("scan advanced on finish");
`endif
endmodule
`default_nettype wire

/* bench/reorder_buffer_tagged_unit_tb.sv */
// Testbench for the tagged reorder buffer: directed and random operations checked against a predictor.
`timescale 1ns / 1ps
module reorder_buffer_tagged_unit_tb;
  import rtb_pkg::*;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_LEN = 400;
  localparam logic [1:0] EXEC_ADDRESS = 2'd1;
  localparam logic [1:0] EXEC_BAD = 2'd3;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0] op;
    logic [31:0] tag, dval;
    logic [1:0] ekind, kind;
    logic [4:0] dest;
    logic halt;
    logic [31:0] pc, ppc;
    logic vrdy, crdy;
    logic [31:0] ckpt;
  } rob_op_t;

  typedef struct {
    logic [1:0] status;
    logic [31:0] new_tag;
    logic cv, ch;
    logic [4:0] cd;
    logic [1:0] ck;
    logic [31:0] cval, cpc, cppc, cckpt;
    logic qr;
    logic [31:0] qv;
  } rob_res_t;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, out_stall = 1'b0;
  logic in_stall, out_valid;
  logic [2:0] operation = '0;
  logic [31:0] tag = '0, data_value = '0, instr_pc = '0, predicted_pc = '0, checkpoint = '0;
  logic [1:0] exec_kind = '0, entry_kind = '0;
  logic [4:0] dest_reg = '0;
  logic halt_flag = 1'b0, push_value_ready = 1'b0, push_commit_ready = 1'b0;
  logic [1:0] status, commit_kind;
  logic [31:0] new_tag, commit_value, commit_pc, commit_predicted_pc, commit_checkpoint;
  logic [31:0] query_value;
  logic commit_valid, commit_halt, query_ready;
  logic [4:0] commit_dest;

  reorder_buffer_tagged_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  int head_p, tail_p;
  logic [31:0] tag_counter;
  logic [31:0] s_tag[SLOTS], s_val[SLOTS], s_pc[SLOTS], s_ppc[SLOTS], s_ckpt[SLOTS];
  logic [1:0] s_kind[SLOTS];
  logic [4:0] s_dest[SLOTS];
  logic s_halt[SLOTS], s_vflag[SLOTS], s_cflag[SLOTS];

  rob_res_t pending_results[$];
  int errs = 0;
  int tx_idle_pct = 0, rx_stall_pct = 0;
  bit hold_req = 0, hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  function automatic int occupancy();
    return (tail_p - head_p + SLOTS) % SLOTS;
  endfunction

  function automatic int find_live(logic [31:0] t);
    int i;
    i = head_p;
    while (i != tail_p) begin
      if (s_tag[i] == t) return i;
      i = (i + 1) % SLOTS;
    end
    return -1;
  endfunction

  function automatic rob_res_t rob_predict(rob_op_t it);
    rob_res_t r;
    int i;
    r = '{default: '0};
    case (it.op) inside
      OP_PUSH: begin
        if ((tail_p + 1) % SLOTS == head_p) r.status = ST_FULL;
        else begin
          i = tail_p;
          tag_counter = tag_counter + 32'd1;
          s_tag[i] = tag_counter; s_kind[i] = it.kind; s_dest[i] = it.dest;
          s_halt[i] = it.halt; s_pc[i] = it.pc; s_ppc[i] = it.ppc; s_val[i] = it.dval;
          s_cflag[i] = it.crdy; s_vflag[i] = it.vrdy | it.crdy; s_ckpt[i] = it.ckpt;
          tail_p = (tail_p + 1) % SLOTS;
          r.new_tag = tag_counter;
        end
      end
      OP_EXEC, OP_BRANCH, OP_QUERY: begin
        i = find_live(it.tag);
        if (i < 0) r.status = ST_NOTFOUND;
        else if (it.op == OP_EXEC) begin
          if (it.ekind == EXEC_NORMAL && s_kind[i] == KIND_REG) begin
            s_val[i] = it.dval; s_vflag[i] = 1'b1; s_cflag[i] = 1'b1;
          end else if (it.ekind == EXEC_NORMAL && s_kind[i] == KIND_STORE) s_cflag[i] = 1'b1;
          else if (it.ekind == EXEC_CONTROL && s_kind[i] == KIND_LINK) s_cflag[i] = 1'b1;
        end else if (it.op == OP_BRANCH) begin
          if (s_kind[i] == KIND_BRANCH) s_cflag[i] = 1'b1;
        end else begin
          r.qr = s_vflag[i]; r.qv = s_val[i];
        end
      end
      OP_SQUASH: begin
        i = head_p;
        while (i != tail_p) begin
          if (s_tag[i] > it.tag) begin
            tail_p = i;
            break;
          end
          i = (i + 1) % SLOTS;
        end
      end
      OP_COMMIT: begin
        i = head_p;
        if (i == tail_p || !s_cflag[i]) r.status = ST_HEAD_NR;
        else begin
          r.cv = 1'b1; r.ch = s_halt[i]; r.cd = s_dest[i]; r.ck = s_kind[i];
          r.cval = s_val[i]; r.cpc = s_pc[i]; r.cppc = s_ppc[i]; r.cckpt = s_ckpt[i];
          head_p = (head_p + 1) % SLOTS;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_op(rob_op_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    operation = it.op; tag = it.tag; data_value = it.dval; exec_kind = it.ekind;
    entry_kind = it.kind; dest_reg = it.dest; halt_flag = it.halt; instr_pc = it.pc;
    predicted_pc = it.ppc; push_value_ready = it.vrdy; push_commit_ready = it.crdy;
    checkpoint = it.ckpt;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(rob_predict(it));
    @(negedge clk);
  endtask

  function automatic rob_op_t mk_op(logic [2:0] op, logic [31:0] t);
    rob_op_t it;
    it.op = op; it.tag = t; it.dval = $urandom; it.ekind = 2'($urandom_range(3));
    it.kind = 2'($urandom_range(3)); it.dest = 5'($urandom); it.halt = 1'($urandom);
    it.pc = $urandom; it.ppc = $urandom; it.vrdy = 1'($urandom);
    it.crdy = $urandom_range(3) == 0;
    it.ckpt = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] near_tag();
    if ($urandom_range(19) == 0) return $urandom;
    return tag_counter - $urandom_range(occupancy() + 1);
  endfunction

  function automatic rob_op_t rand_op();
    int w;
    w = $urandom_range(99);
    if (w < 30) return mk_op(OP_PUSH, $urandom);
    if (w < 50) return mk_op(OP_EXEC, near_tag());
    if (w < 60) return mk_op(OP_BRANCH, near_tag());
    if (w < 73) return mk_op(OP_QUERY, near_tag());
    if (w < 78) return mk_op(OP_SQUASH, near_tag());
    if (w < 98) return mk_op(OP_COMMIT, $urandom);
    return mk_op($urandom_range(1) ? OP_SPARE6 : OP_SPARE7, $urandom);
  endfunction

  task automatic chk(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errs++;
      if (errs <= 10) $display("mismatch %s: expected %h got %h", name, e, a);
    end
  endtask

  always @(posedge clk) begin
    rob_res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("reorder_buffer_tagged_unit_tb: done, errors");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result transfer");
      end else begin
        e = pending_results.pop_front();
        chk("status", 32'(e.status), 32'(status));
        chk("new_tag", e.new_tag, new_tag);
        chk("commit_valid", 32'(e.cv), 32'(commit_valid));
        chk("commit_halt", 32'(e.ch), 32'(commit_halt));
        chk("commit_dest", 32'(e.cd), 32'(commit_dest));
        chk("commit_kind", 32'(e.ck), 32'(commit_kind));
        chk("commit_value", e.cval, commit_value);
        chk("commit_pc", e.cpc, commit_pc);
        chk("commit_predicted_pc", e.cppc, commit_predicted_pc);
        chk("commit_checkpoint", e.cckpt, commit_checkpoint);
        chk("query_ready", 32'(e.qr), 32'(query_ready));
        chk("query_value", e.qv, query_value);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen = 1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else out_stall = ($urandom_range(99) < rx_stall_pct);
  end

  task automatic test_directed();
    rob_op_t it;
    logic [31:0] t0;
    send_op(mk_op(OP_COMMIT, '0));
    send_op(mk_op(OP_QUERY, 32'hFFFF_FFFF));
    t0 = tag_counter;
    for (int k = 0; k < 4; k++) begin
      it = mk_op(OP_PUSH, '0);
      it.kind = 2'(k); it.vrdy = 1'b0; it.crdy = 1'b0;
      it.dest = k[0] ? 5'd31 : 5'd0; it.halt = k[0];
      it.pc = k[0] ? '1 : '0; it.ppc = k[0] ? '0 : '1; it.ckpt = k[0] ? '1 : '0;
      it.dval = k[0] ? '0 : '1;
      send_op(it);
    end
    it = mk_op(OP_PUSH, '0); it.vrdy = 1'b0; it.crdy = 1'b1;
    send_op(it);
    it = mk_op(OP_EXEC, t0 + 1); it.ekind = EXEC_ADDRESS; send_op(it);
    it = mk_op(OP_EXEC, t0 + 1); it.ekind = EXEC_BAD; send_op(it);
    it = mk_op(OP_EXEC, t0 + 1); it.ekind = EXEC_NORMAL; send_op(it);
    it = mk_op(OP_EXEC, t0 + 2); it.ekind = EXEC_NORMAL; send_op(it);
    send_op(mk_op(OP_BRANCH, t0 + 1));
    send_op(mk_op(OP_BRANCH, t0 + 3));
    it = mk_op(OP_EXEC, t0 + 4); it.ekind = EXEC_CONTROL; send_op(it);
    send_op(mk_op(OP_QUERY, t0 + 1));
    send_op(mk_op(OP_QUERY, t0 + 5));
    send_op(mk_op(OP_SQUASH, 32'hFFFF_FFFF));
    send_op(mk_op(OP_SPARE6, '0));
    send_op(mk_op(OP_SPARE7, '1));
    send_op(mk_op(OP_SQUASH, t0 + 4));
    for (int k = 0; k < 5; k++) send_op(mk_op(OP_COMMIT, '0));
  endtask

  task automatic test_fill_under_hold();
    rob_op_t it;
    hold_req = 1;
    for (int k = 0; k < 70; k++) begin
      it = mk_op(OP_PUSH, '0); it.crdy = 1'b1;
      send_op(it);
    end
    for (int k = 0; k < 10; k++) send_op(mk_op(OP_COMMIT, '0));
    send_op(mk_op(OP_SQUASH, '0));
  endtask

  task automatic test_random(int n, int tx, int rx);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    repeat (n) send_op(rand_op());
  endtask

  initial begin
    head_p = 0; tail_p = 0; tag_counter = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fill_under_hold();
    test_random(300, 0, 0);
    test_random(300, 77, 0);
    test_random(300, 0, 77);
    test_random(300, 12, 12);
    test_random(100, 0, 0);
    in_valid = 1'b0;
    rx_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 10) @(posedge clk);
    if (errs == 0 && pending_results.size() == 0)
      $display("reorder_buffer_tagged_unit_tb: done, clean");
    else
      $display("reorder_buffer_tagged_unit_tb: done, errors");
    $finish;
  end
endmodule
